// File: design/iqdc_pkg.sv
// package: shared types, constants and cosine table builder for the iq down-converter
`timescale 1ns / 1ps

package iqdc_pkg;

  // table size default and register layout
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FILT_W     = 24;
  localparam int unsigned OPA_W      = 25;
  localparam int unsigned OPB_W      = 17;
  localparam int unsigned PROD_W     = OPA_W + OPB_W;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 1'd1;

  localparam logic [31:0] PHASE_STEP_RST = 32'd107374182;
  localparam logic [15:0] SMOOTHING_RST  = 16'd62259;

  // fixed-point constants of the table generator
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned ONE_Q30    = 64'd1073741824;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_COS,
    ST_MUL_SIN,
    ST_MUL_FI,
    ST_MUL_FQ,
    ST_DONE
  } state_e;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_SAMPLE_ROM,
    MUL_DIFF_I,
    MUL_DIFF_Q
  } mul_sel_e;

  // sequencer to datapath controls
  typedef struct packed {
    logic     ready;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     rom_sin;
    logic     ld_xi;
    logic     ld_xq;
    logic     upd_i;
    logic     finish;
  } ctrl_t;

  // unsigned quotient by shift and subtract, used while building the table
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
      rem = (rem << 1) | ((n >> bit_idx) & 64'd1);
      quo = quo << 1;
      if (rem >= d) begin
        rem = rem - d;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // cosine table entry k of a table with 2^ab entries, Q1.15, quarter-wave symmetric
  function automatic logic signed [15:0] cos_entry(int unsigned k, int unsigned ab);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned c;
    longint unsigned m;
    longint          sum;
    int unsigned     size;
    int unsigned     q;
    logic            neg;
    size = 32'd1 << ab;
    q    = size >> 2;
    if (k <= q) begin
      m = k; neg = 1'b0;
    end else if (k < 2 * q) begin
      m = 2 * q - k; neg = 1'b1;
    end else if (k <= 3 * q) begin
      m = k - 2 * q; neg = 1'b1;
    end else begin
      m = size - k; neg = 1'b0;
    end
    theta = (TWO_PI_Q30 * m) >> ab;
    t2    = (theta * theta) >> 30;
    term  = ONE_Q30;
    sum   = longint'(ONE_Q30);
    // taylor series in q2.30, eleven terms
    for (int j = 1; j <= 10; j++) begin
      term = (term * t2) >> 30;
      term = udiv64(term, 64'((2 * j - 1) * (2 * j)));
      if ((j & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    c = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (neg) return -16'(c);
    return 16'(c);
  endfunction

endpackage

// File: design/iqdc_if.sv
// interfaces: sample channel and result channel
`timescale 1ns / 1ps

interface iqdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface iqdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_phase;
  logic signed [15:0] quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

// File: design/iqdc_cos_rom.sv
// cosine rom with registered read, contents fixed at elaboration
`timescale 1ns / 1ps

module iqdc_cos_rom #(
  parameter int unsigned ADDR_BITS = iqdc_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  output logic signed [15:0]   data_o
);
  import iqdc_pkg::*;

  localparam int unsigned SIZE = 1 << ADDR_BITS;

  logic signed [15:0] rom_w [SIZE];
  logic signed [15:0] data_q;

  // table contents
  for (genvar k = 0; k < SIZE; k++) begin : g_rom
    localparam logic signed [15:0] VAL = cos_entry(k, ADDR_BITS);
    assign rom_w[k] = VAL;
  end

  // registered read
  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// File: design/iqdc_mult.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module iqdc_mult (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [iqdc_pkg::OPA_W-1:0]   a_i,
  input  logic signed [iqdc_pkg::OPB_W-1:0]   b_i,
  output logic signed [iqdc_pkg::PROD_W-1:0]  prod_o
);
  import iqdc_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // product register, loaded when a step needs the unit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: design/iqdc_seq.sv
// sequencer stepping the shared multiplier through mix and filter products
`timescale 1ns / 1ps

module iqdc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  output iqdc_pkg::ctrl_t ctrl_o
);
  import iqdc_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_MUL_COS;
      ST_MUL_COS: state_d = ST_MUL_SIN;
      ST_MUL_SIN: state_d = ST_MUL_FI;
      ST_MUL_FI:  state_d = ST_MUL_FQ;
      ST_MUL_FQ:  state_d = ST_DONE;
      ST_DONE:    if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // step controls
  always_comb begin
    ctrl_o = '0;
    ctrl_o.mul_sel = MUL_SAMPLE_ROM;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.ready = 1'b1;
      end
      ST_MUL_COS: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.rom_sin = 1'b1;
      end
      ST_MUL_SIN: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.ld_xi  = 1'b1;
      end
      ST_MUL_FI: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_DIFF_I;
        ctrl_o.ld_xq   = 1'b1;
      end
      ST_MUL_FQ: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_DIFF_Q;
        ctrl_o.upd_i   = 1'b1;
      end
      ST_DONE: begin
        ctrl_o.finish = out_free_i;
      end
      default: begin
        ctrl_o.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/iq_downconvert_lowpass.sv
// top level: quadrature down-converter with one-pole low-pass on i and q
//
//   channel      dir  handshake        word
//   sample_ch_i  in   valid / ready    sample, restart
//   result_ch_o  out  valid / ready    in_phase, quadrature
//   cfg          in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// one sample passes through the accept state plus five steps, four of which
// go through the one shared multiplier (cos mix, sin mix, i filter, q filter).
// reset clears phase, filters and the loaded flag; no clearing pass is needed.
// the result sits in an output register; the next sample is accepted while it
// waits, and only the final step holds if the previous result is still there.
`timescale 1ns / 1ps

module iq_downconvert_lowpass #(
  parameter int unsigned TABLE_ADDR_BITS = iqdc_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  iqdc_in_if.sink                           sample_ch_i,
  iqdc_out_if.source                        result_ch_o,
  input  logic                              cfg_we_i,
  input  logic [iqdc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [iqdc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import iqdc_pkg::*;

  localparam int unsigned AB = TABLE_ADDR_BITS;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  ctrl_t ctrl;

  logic [31:0]              phase_step_q;
  logic [15:0]              smooth_q;
  logic [31:0]              phase_q;
  logic [31:0]              phase_eff;
  logic [AB-1:0]            addr_c;
  logic [AB-1:0]            addr_q;
  logic [AB-1:0]            rom_addr;
  logic signed [15:0]       rom_data;
  logic signed [15:0]       sample_q;
  logic                     loaded_q;
  logic                     accept;
  logic                     out_free;
  logic                     out_valid_q;
  logic signed [15:0]       out_i_q;
  logic signed [15:0]       out_q_q;
  logic signed [FILT_W-1:0] xi_q;
  logic signed [FILT_W-1:0] xq_q;
  logic signed [FILT_W-1:0] i_filt_q;
  logic signed [FILT_W-1:0] q_filt_q;
  logic signed [FILT_W-1:0] q_filt_d;
  logic signed [FILT_W-1:0] i_filt_d;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // filter step: x + round((prev - x) * a / 2^16), clamped; load passes x
  function automatic logic signed [FILT_W-1:0] filt_next(
    input logic signed [FILT_W-1:0] x,
    input logic signed [PROD_W-1:0] p,
    input logic                     loaded
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [26:0]       v;
    rnd = p + PROD_W'(32768);
    v   = 27'(x) + 27'($signed(rnd[PROD_W-1:16]));
    if (!loaded)                 return x;
    if (v > 27'sd8388607)        return 24'sh7fffff;
    if (v < -27'sd8388608)       return 24'sh800000;
    return v[FILT_W-1:0];
  endfunction

  // filter register to q1.15, rounded half up and saturated
  function automatic logic signed [15:0] to_output(input logic signed [FILT_W-1:0] f);
    logic signed [FILT_W:0] v;
    v = 25'(f) + 25'sd128;
    if ($signed(v[FILT_W:8]) > 17'sd32767)  return 16'sh7fff;
    if ($signed(v[FILT_W:8]) < -17'sd32768) return 16'sh8000;
    return v[23:8];
  endfunction

  iqdc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_ch_i.valid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // handshakes
  assign sample_ch_i.ready = ctrl.ready;
  assign accept   = sample_ch_i.valid && ctrl.ready;
  assign out_free = !out_valid_q || result_ch_o.ready;

  // carrier phase and table addresses
  assign phase_eff = sample_ch_i.restart ? 32'd0 : phase_q;
  assign addr_c    = phase_eff[31 -: AB];
  assign rom_addr  = ctrl.rom_sin ? (addr_q - QUARTER) : addr_c;

  iqdc_cos_rom #(.ADDR_BITS(AB)) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // shared multiplier operands
  always_comb begin
    case (ctrl.mul_sel)
      MUL_SAMPLE_ROM: begin
        mul_a = OPA_W'(sample_q);
        mul_b = OPB_W'(rom_data);
      end
      MUL_DIFF_I: begin
        mul_a = OPA_W'(i_filt_q) - OPA_W'(xi_q);
        mul_b = OPB_W'({1'b0, smooth_q});
      end
      MUL_DIFF_Q: begin
        mul_a = OPA_W'(q_filt_q) - OPA_W'(xq_q);
        mul_b = OPB_W'({1'b0, smooth_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  iqdc_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign i_filt_d = filt_next(xi_q, prod, loaded_q);
  assign q_filt_d = filt_next(xq_q, prod, loaded_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      smooth_q     <= SMOOTHING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        CFG_SMOOTHING:  smooth_q     <= cfg_data_i[15:0];
        default:        phase_step_q <= phase_step_q;
      endcase
    end
  end

  // sample capture and mixer products, floor shift by 7
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_ch_i.sample;
      addr_q   <= addr_c;
    end
    if (ctrl.ld_xi) xi_q <= prod[30:7];
    if (ctrl.ld_xq) xq_q <= prod[30:7];
  end

  // phase accumulator, filter state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      loaded_q    <= 1'b0;
      i_filt_q    <= '0;
      q_filt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_eff + phase_step_q;
        if (sample_ch_i.restart) loaded_q <= 1'b0;
      end
      if (ctrl.upd_i) i_filt_q <= i_filt_d;
      if (ctrl.finish) begin
        q_filt_q    <= q_filt_d;
        loaded_q    <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (result_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_i_q <= to_output(i_filt_q);
      out_q_q <= to_output(q_filt_d);
    end
  end

  assign result_ch_o.valid      = out_valid_q;
  assign result_ch_o.in_phase   = out_i_q;
  assign result_ch_o.quadrature = out_q_q;

endmodule

// File: tb/sv/iq_downconvert_lowpass_tb.sv
// testbench: iq down-converter with low-pass, checked word by word against a built-in predictor
`timescale 1ns / 1ps

module iq_downconvert_lowpass_tb;
  import iqdc_pkg::*;

  localparam int unsigned ADDR_BITS = TABLE_ADDR_BITS_DEF;
  localparam int unsigned TSIZE     = 1 << ADDR_BITS;
  localparam int unsigned N_DIRECT  = 19;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned PHASE_LEN = 200;
  localparam int unsigned CYC_LIMIT = 400000;

  // angle and unity in q2.30 for the cosine series
  localparam longint unsigned TURN_Q30  = 64'd6746518852;
  localparam longint unsigned UNITY_Q30 = 64'd1073741824;

  typedef struct packed {
    logic signed [15:0] in_phase;
    logic signed [15:0] quadrature;
  } iq_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               restart;
    logic               given;
    iq_word_t           known;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  iqdc_in_if  in_ch ();
  iqdc_out_if out_ch ();

  iq_downconvert_lowpass #(
    .TABLE_ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_ch_i(in_ch),
    .result_ch_o(out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // predictor state and register copies
  logic signed [15:0] cos_tab [TSIZE];
  logic [31:0]        carrier_phase;
  logic signed [23:0] i_acc;
  logic signed [23:0] q_acc;
  logic               loaded;
  logic [31:0]        step_cfg;
  logic [15:0]        alpha_cfg;

  iq_word_t    iq_expected_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // cosine of an angle in [0, pi/2], q2.30, truncated taylor series
  function automatic longint unsigned cos_series(input longint unsigned ang);
    longint unsigned sq;
    longint unsigned trm;
    longint          acc;
    sq  = (ang * ang) >> 30;
    trm = UNITY_Q30;
    acc = longint'(UNITY_Q30);
    for (int n = 1; n <= 10; n++) begin
      trm = (trm * sq) >> 30;
      trm = trm / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc = acc - longint'(trm);
      else            acc = acc + longint'(trm);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(UNITY_Q30)) acc = longint'(UNITY_Q30);
    return longint'(acc);
  endfunction

  // first-quadrant amplitude in q1.15, rounded half up
  function automatic logic signed [15:0] quarter_amp(input int unsigned m);
    longint unsigned c;
    c = cos_series((TURN_Q30 * m) >> ADDR_BITS);
    return 16'((c * 64'd32767 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic void build_cos_tab();
    int unsigned q;
    q = TSIZE / 4;
    for (int unsigned k = 0; k < TSIZE; k++) begin
      if (k <= q)          cos_tab[k] = quarter_amp(k);
      else if (k < 2 * q)  cos_tab[k] = -quarter_amp(2 * q - k);
      else if (k <= 3 * q) cos_tab[k] = -quarter_amp(k - 2 * q);
      else                 cos_tab[k] = quarter_amp(TSIZE - k);
    end
  endfunction

  function automatic logic signed [23:0] clamp_q23(input longint v);
    if (v > 64'sd8388607)  return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

  // one-pole update: x + round((prev - x) * alpha / 2^16)
  function automatic logic signed [23:0] lowpass_step(input logic signed [23:0] prev,
                                                      input longint x);
    longint d;
    longint p;
    d = longint'(prev) - x;
    p = d * longint'(alpha_cfg) + 64'sd32768;
    return clamp_q23(x + (p >>> 16));
  endfunction

  // q1.23 to q1.15, rounded half up, saturated
  function automatic logic signed [15:0] narrow_q15(input logic signed [23:0] f);
    longint v;
    v = (longint'(f) + 64'sd128) >>> 8;
    if (v > 64'sd32767)  return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // mix the sample down with cos and sin, filter, advance the carrier
  function automatic iq_word_t predict_iq(input logic signed [15:0] s, input logic restart);
    logic [ADDR_BITS-1:0] a_cos;
    logic [ADDR_BITS-1:0] a_sin;
    longint               x_i;
    longint               x_q;
    iq_word_t             w;
    if (restart) begin
      carrier_phase = '0;
      loaded        = 1'b0;
    end
    a_cos = carrier_phase[31 -: ADDR_BITS];
    a_sin = a_cos - ADDR_BITS'(TSIZE / 4);
    x_i = (longint'(s) * longint'(cos_tab[a_cos])) >>> 7;
    x_q = (longint'(s) * longint'(cos_tab[a_sin])) >>> 7;
    if (!loaded) begin
      i_acc  = clamp_q23(x_i);
      q_acc  = clamp_q23(x_q);
      loaded = 1'b1;
    end else begin
      i_acc = lowpass_step(i_acc, x_i);
      q_acc = lowpass_step(q_acc, x_q);
    end
    carrier_phase = carrier_phase + step_cfg;
    w.in_phase   = narrow_q15(i_acc);
    w.quadrature = narrow_q15(q_acc);
    return w;
  endfunction

  // offer one word with random idle in front; queue its expected result on accept
  task automatic send_sample(input logic signed [15:0] s, input logic restart,
                             input logic given, input iq_word_t known);
    iq_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= restart;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = predict_iq(s, restart);
    iq_expected_q.push_back(given ? known : pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PHASE_STEP: step_cfg = val;
      CFG_SMOOTHING:  alpha_cfg = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // stop offering and let every outstanding result drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (iq_expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1:       return 16'($urandom_range(1023)) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // runs of random samples, mostly led by one or more restarts, with stray restarts mixed in
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned held;
    int unsigned run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15)      held = $urandom_range(4, 2);
      else if ($urandom_range(99) < 85) held = 1;
      else                              held = 0;
      repeat (held) begin
        send_sample(pick_sample(), 1'b1, 1'b0, '0);
        sent++;
      end
      run_len = $urandom_range(40, 3);
      repeat (run_len) begin
        send_sample(pick_sample(), $urandom_range(63) == 0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result side: random stall, compare each word with the oldest expectation
  initial begin
    iq_word_t exp_w;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (iq_expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected word: i=%0d q=%0d", out_ch.in_phase, out_ch.quadrature);
        end else begin
          exp_w = iq_expected_q.pop_front();
          if (out_ch.in_phase !== exp_w.in_phase || out_ch.quadrature !== exp_w.quadrature) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch at cycle %0d: expected i=%0d q=%0d, got i=%0d q=%0d",
                       cycle_cnt, exp_w.in_phase, exp_w.quadrature,
                       out_ch.in_phase, out_ch.quadrature);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // timeout
  initial begin
    while (cycle_cnt < CYC_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // directed rows: first word after reset, extremes, restart held high
  stim_row_t dir_rows [N_DIRECT] = '{
    '{16'sh7FFF, 1'b0, 1'b1, '{16'sd32766, 16'sd0}},
    '{16'sh8000, 1'b0, 1'b0, '0},
    '{16'sh0000, 1'b0, 1'b0, '0},
    '{16'sh0001, 1'b0, 1'b0, '0},
    '{16'shFFFF, 1'b0, 1'b0, '0},
    '{16'sh5555, 1'b0, 1'b0, '0},
    '{16'shAAAA, 1'b0, 1'b0, '0},
    '{16'sh7FFF, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b1, 1'b1, '{-16'sd32767, 16'sd0}},
    '{16'sh0000, 1'b1, 1'b1, '{16'sd0, 16'sd0}},
    '{16'sh7FFF, 1'b1, 1'b1, '{16'sd32766, 16'sd0}},
    '{16'sh8000, 1'b1, 1'b1, '{-16'sd32767, 16'sd0}},
    '{16'sd12345, 1'b1, 1'b0, '0},
    '{-16'sd12345, 1'b0, 1'b0, '0},
    '{16'sh7FFF, 1'b0, 1'b0, '0},
    '{16'sh7FFF, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b0, 1'b0, '0},
    '{16'sh0100, 1'b0, 1'b0, '0}
  };

  // main sequence
  initial begin
    logic [31:0] ph_step;
    logic [15:0] ph_alpha;
    build_cos_tab();
    carrier_phase = '0;
    i_acc         = '0;
    q_acc         = '0;
    loaded        = 1'b0;
    step_cfg      = PHASE_STEP_RST;
    alpha_cfg     = SMOOTHING_RST;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_PHASE_STEP;
    cfg_data      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < N_DIRECT; r++) begin
      send_sample(dir_rows[r].sample, dir_rows[r].restart, dir_rows[r].given,
                  dir_rows[r].known);
    end

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin ph_step = PHASE_STEP_RST;          ph_alpha = SMOOTHING_RST; end
        1: begin ph_step = 32'h0000_0000;           ph_alpha = 16'h0000;      end
        2: begin ph_step = 32'hFFFF_FFFF;           ph_alpha = 16'hFFFF;      end
        4: begin ph_step = 32'h4000_0000;           ph_alpha = 16'h8000;      end
        5: begin ph_step = $urandom_range(32'h0100_0000, 0);
                 ph_alpha = 16'($urandom_range(65535, 60000)); end
        6: begin ph_step = 32'h8000_0000;           ph_alpha = 16'h0001;      end
        default: begin ph_step = $urandom; ph_alpha = 16'($urandom); end
      endcase
      write_reg(CFG_PHASE_STEP, ph_step);
      write_reg(CFG_SMOOTHING, {16'h0000, ph_alpha});
      // idling mix: none, sender, receiver, both
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      run_random(PHASE_LEN);
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (mismatch_cnt == 0 && iq_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/iqdc_pkg.sv
design/iqdc_if.sv
design/iqdc_cos_rom.sv
design/iqdc_mult.sv
design/iqdc_seq.sv
design/iq_downconvert_lowpass.sv
tb/sv/iq_downconvert_lowpass_tb.sv
